@@ rtl/tile_residency_window_unit_macros.svh @@
// Assertion macros shared by the tile residency window RTL.
`ifndef TILE_RESIDENCY_WINDOW_UNIT_MACROS_SVH
`define TILE_RESIDENCY_WINDOW_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Checks a condition at every clock edge outside reset.
`define TRW_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Checks that a trigger is followed by a consequence in the next cycle.
`define TRW_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);
`else
`define TRW_ASSERT(label, cond, msg)
`define TRW_ASSERT_NEXT(label, trig, cons, msg)
`endif

`endif

@@ rtl/trw_pkg.sv @@
// Shared constants, types and helpers for the tile residency window unit.
`timescale 1ns / 1ps
`default_nettype none

package trw_pkg;

	// Tile size must be a power of two; the grid mapping is an arithmetic shift.
	localparam int TILE_SIZE     = 256;
	localparam int VIEW_DISTANCE = 1;
	localparam int TILE_SHIFT    = $clog2(TILE_SIZE);
	localparam int DIAMETER      = 2 * VIEW_DISTANCE + 1;
	localparam int NSLOTS        = DIAMETER * DIAMETER;
	localparam int SLOT_W        = $clog2(NSLOTS);
	localparam int WIN_W         = $clog2(DIAMETER);
	localparam int GRID_W        = 24;
	localparam int WORLD_W       = 32;
	localparam int KIND_W        = 3;
	localparam int SLOT_OUT_W    = 5;

	typedef enum logic [KIND_W-1:0] {
		EV_DEACT  = 3'd0,
		EV_ACT    = 3'd1,
		EV_HIT    = 3'd2,
		EV_NOFREE = 3'd3,
		EV_DONE   = 3'd4
	} event_kind_t;

	typedef enum logic [1:0] {
		MODE_ACCESS = 2'd0,
		MODE_SWEEP  = 2'd1,
		MODE_WINDOW = 2'd2,
		MODE_DONE   = 2'd3
	} mode_t;

	typedef struct packed {
		logic  load;
		logic  step;
		mode_t mode;
	} trw_cmd_t;

	typedef struct packed {
		logic emit_req;
		logic cnt_end;
		logic out_free;
	} trw_stat_t;

	// Floor division of a world coordinate by the tile size, wrapped to grid width.
	function automatic logic [GRID_W-1:0] grid_of(input logic [WORLD_W-1:0] w);
		logic signed [2*WORLD_W-1:0] wide;
		logic signed [2*WORLD_W-1:0] shifted;
		wide    = {{WORLD_W{w[WORLD_W-1]}}, w};
		shifted = wide >>> TILE_SHIFT;
		return shifted[GRID_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/trw_ctrl.sv @@
// Controller state machine that sequences access and camera items.
`timescale 1ns / 1ps
`default_nettype none

module trw_ctrl import trw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      op,
	input  trw_stat_t stat,
	output trw_cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_ACCESS = 5'b00010,
		ST_SWEEP  = 5'b00100,
		ST_WINDOW = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.load = in_valid && in_ready;
		cmd.step = (state_q != ST_IDLE) && (!stat.emit_req || stat.out_free);
		case (state_q)
			ST_SWEEP:  cmd.mode = MODE_SWEEP;
			ST_WINDOW: cmd.mode = MODE_WINDOW;
			ST_DONE:   cmd.mode = MODE_DONE;
			default:   cmd.mode = MODE_ACCESS;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) begin
					state_d = op ? ST_ACCESS : ST_SWEEP;
				end
			end
			ST_ACCESS: begin
				if (cmd.step) begin
					state_d = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				if (cmd.step && stat.cnt_end) begin
					state_d = ST_WINDOW;
				end
			end
			ST_WINDOW: begin
				if (cmd.step && stat.cnt_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (cmd.step) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/trw_datapath.sv @@
// Slot table, lookup and claim logic, window counters and output register.
`timescale 1ns / 1ps
`default_nettype none

`include "tile_residency_window_unit_macros.svh"

module trw_datapath import trw_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [WORLD_W-1:0]       world_x,
	input  logic [WORLD_W-1:0]       world_y,
	input  trw_cmd_t                 cmd,
	output trw_stat_t                stat,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [KIND_W-1:0]        event_kind,
	output logic [SLOT_OUT_W-1:0]    slot_index,
	output logic signed [GRID_W-1:0] tile_x,
	output logic signed [GRID_W-1:0] tile_y,
	output logic                     last
);

	localparam logic signed [GRID_W-1:0] VD_POS = GRID_W'(VIEW_DISTANCE);
	localparam logic signed [GRID_W-1:0] VD_NEG = -VD_POS;

	logic              act_q [NSLOTS];
	logic [GRID_W-1:0] sx_q  [NSLOTS];
	logic [GRID_W-1:0] sy_q  [NSLOTS];
	logic [GRID_W-1:0] gx_q;
	logic [GRID_W-1:0] gy_q;
	logic [SLOT_W-1:0] cnt_q;
	logic [WIN_W-1:0]  wx_q;
	logic [WIN_W-1:0]  wy_q;

	logic                     out_valid_q;
	logic [KIND_W-1:0]        kind_q;
	logic [SLOT_W-1:0]        slot_q;
	logic [GRID_W-1:0]        ox_q;
	logic [GRID_W-1:0]        oy_q;
	logic                     last_q;

	logic [GRID_W-1:0]        tgt_x;
	logic [GRID_W-1:0]        tgt_y;
	logic [NSLOTS-1:0]        hit_vec;
	logic [NSLOTS-1:0]        free_vec;
	logic                     hit_any;
	logic                     free_any;
	logic [SLOT_W-1:0]        hit_idx;
	logic [SLOT_W-1:0]        free_idx;
	logic signed [GRID_W-1:0] dist_x;
	logic signed [GRID_W-1:0] dist_y;
	logic                     far;
	logic                     emit_req;
	logic                     do_free;
	logic                     do_claim;
	event_kind_t              ev_kind;
	logic [SLOT_W-1:0]        ev_slot;
	logic [GRID_W-1:0]        ev_x;
	logic [GRID_W-1:0]        ev_y;
	logic                     ev_last;

	// Window tiles are the camera tile plus an offset in minus to plus view distance.
	always_comb begin
		if (cmd.mode == MODE_WINDOW) begin
			tgt_x = gx_q + GRID_W'(wx_q) - VD_POS;
			tgt_y = gy_q + GRID_W'(wy_q) - VD_POS;
		end else begin
			tgt_x = gx_q;
			tgt_y = gy_q;
		end
	end

	// Associative compare over all slots; the lowest index wins in each vector.
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < NSLOTS; i++) begin
			hit_vec[i]  = act_q[i] && (sx_q[i] == tgt_x) && (sy_q[i] == tgt_y);
			free_vec[i] = !act_q[i];
		end
		for (int i = NSLOTS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx = SLOT_W'(i);
			end
			if (free_vec[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
		hit_any  = |hit_vec;
		free_any = |free_vec;
	end

	assign dist_x = sx_q[cnt_q] - gx_q;
	assign dist_y = sy_q[cnt_q] - gy_q;
	assign far    = (dist_x > VD_POS) || (dist_x < VD_NEG) ||
	                (dist_y > VD_POS) || (dist_y < VD_NEG);

	always_comb begin
		emit_req = 1'b1;
		ev_kind  = EV_DONE;
		ev_slot  = '0;
		ev_x     = gx_q;
		ev_y     = gy_q;
		ev_last  = 1'b1;
		case (cmd.mode)
			MODE_SWEEP: begin
				emit_req = act_q[cnt_q] && far;
				ev_kind  = EV_DEACT;
				ev_slot  = cnt_q;
				ev_x     = sx_q[cnt_q];
				ev_y     = sy_q[cnt_q];
				ev_last  = 1'b0;
			end
			MODE_WINDOW: begin
				emit_req = !hit_any && free_any;
				ev_kind  = EV_ACT;
				ev_slot  = free_idx;
				ev_x     = tgt_x;
				ev_y     = tgt_y;
				ev_last  = 1'b0;
			end
			MODE_ACCESS: begin
				if (hit_any) begin
					ev_kind = EV_HIT;
					ev_slot = hit_idx;
				end else if (free_any) begin
					ev_kind = EV_ACT;
					ev_slot = free_idx;
				end else begin
					ev_kind = EV_NOFREE;
				end
				ev_x = tgt_x;
				ev_y = tgt_y;
			end
			default: begin
				ev_kind = EV_DONE;
			end
		endcase
	end

	assign do_free  = cmd.step && (cmd.mode == MODE_SWEEP) && emit_req;
	assign do_claim = cmd.step && (((cmd.mode == MODE_WINDOW) && emit_req) ||
	                               ((cmd.mode == MODE_ACCESS) && !hit_any && free_any));

	always_comb begin
		stat.emit_req = emit_req;
		stat.out_free = !out_valid_q || out_ready;
		case (cmd.mode)
			MODE_SWEEP:  stat.cnt_end = (cnt_q == SLOT_W'(NSLOTS - 1));
			MODE_WINDOW: stat.cnt_end = (wx_q == WIN_W'(DIAMETER - 1)) &&
			                            (wy_q == WIN_W'(DIAMETER - 1));
			default:     stat.cnt_end = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSLOTS; i++) begin
				act_q[i] <= 1'b0;
			end
		end else if (do_free) begin
			act_q[cnt_q] <= 1'b0;
		end else if (do_claim) begin
			act_q[free_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_claim) begin
			sx_q[free_idx] <= tgt_x;
			sy_q[free_idx] <= tgt_y;
		end
		if (cmd.load) begin
			gx_q <= grid_of(world_x);
			gy_q <= grid_of(world_y);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wx_q  <= '0;
			wy_q  <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
			wx_q  <= '0;
			wy_q  <= '0;
		end else if (cmd.step) begin
			if (cmd.mode == MODE_SWEEP) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.mode == MODE_WINDOW) begin
				if (wx_q == WIN_W'(DIAMETER - 1)) begin
					wx_q <= '0;
					wy_q <= wy_q + 1'b1;
				end else begin
					wx_q <= wx_q + 1'b1;
				end
			end
		end
	end

	// Output register: a new beat is loaded only when the previous one is gone or leaving.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step && emit_req) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && emit_req) begin
			kind_q <= ev_kind;
			slot_q <= ev_slot;
			ox_q   <= ev_x;
			oy_q   <= ev_y;
			last_q <= ev_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = kind_q;
	assign slot_index = SLOT_OUT_W'(slot_q);
	assign tile_x     = ox_q;
	assign tile_y     = oy_q;
	assign last       = last_q;

	`TRW_ASSERT(a_single_hit, $onehot0(hit_vec), "more than one slot holds the same tile")
	`TRW_ASSERT(a_no_overwrite, !(cmd.step && emit_req) || !out_valid_q || out_ready, "output beat overwritten before it was taken")
	`TRW_ASSERT_NEXT(a_sweep_frees, do_free, !act_q[$past(cnt_q)], "swept slot still active")
	`TRW_ASSERT_NEXT(a_claim_sets, do_claim, act_q[$past(free_idx)] && out_valid_q, "claimed slot not active or no beat issued")

endmodule

`default_nettype wire

@@ rtl/tile_residency_window_unit.sv @@
// Top level of the tile residency window unit: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a fully associative table of (2*VIEW_DISTANCE+1)^2 tile slots. An access
// beat (op = 1) maps the world position to a grid tile and returns one beat: hit,
// activated or no free slot. After acceptance the controller moves to its access
// state, which loads the result into the output register. A camera beat
// (op = 0) sweeps the slots one per cycle, freeing those out of view, then walks
// the window tiles one per cycle through the shared compare bank, claiming missing
// tiles, and ends with a done beat carrying last; either walk pauses while a result
// waits on out_ready. A new item is taken once the final result of the previous one
// sits in the output register.
module tile_residency_window_unit import trw_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      op,
	input  logic signed [WORLD_W-1:0] world_x,
	input  logic signed [WORLD_W-1:0] world_y,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [KIND_W-1:0]         event_kind,
	output logic [SLOT_OUT_W-1:0]     slot_index,
	output logic signed [GRID_W-1:0]  tile_x,
	output logic signed [GRID_W-1:0]  tile_y,
	output logic                      last
);

	trw_cmd_t  cmd;
	trw_stat_t stat;

	trw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.stat     (stat),
		.cmd      (cmd)
	);

	trw_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.world_x    (world_x),
		.world_y    (world_y),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_kind (event_kind),
		.slot_index (slot_index),
		.tile_x     (tile_x),
		.tile_y     (tile_y),
		.last       (last)
	);

endmodule

`default_nettype wire
